// ===== rtl/ffg_pkg.sv =====
// ----------------------------------------------------------------------------
// ffg_pkg
// Shared widths, codes and types of the fiber frame block.
// ----------------------------------------------------------------------------
package ffg_pkg;

	localparam int FRAC     = 15;
	localparam int UW       = 16;
	localparam int IW       = 24;
	localparam int CW       = 16;
	localparam int CFG_IW   = 1;
	localparam int VW       = 34;
	localparam int MW       = VW - 1;
	localparam int NW       = 30;
	localparam int SW       = 2 * NW + 2;
	localparam int RW       = NW + 1;
	localparam int PW       = $clog2(MW);
	localparam int QB       = FRAC + 1;
	localparam int DNW      = NW + FRAC + 1;
	localparam int SQ_STEPS = SW / 2;
	localparam int UNIT_LAT = 5 + SQ_STEPS + 1 + QB + 1;

	localparam logic [CFG_IW-1:0] CFG_COS = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_SIN = 1'b1;

	typedef logic signed [VW-1:0] wide_t;
	typedef wide_t [2:0] wvec_t;
	typedef logic signed [UW-1:0] q_t;
	typedef q_t [2:0] qvec_t;

	typedef struct packed {
		logic [2:0][IW-1:0] point;
		qvec_t nrm;
		qvec_t w;
		qvec_t f;
		qvec_t gf;
	} side_t;

	typedef struct packed {
		logic signed [IW-1:0] grad_x;
		logic signed [IW-1:0] grad_y;
		logic signed [IW-1:0] grad_z;
		logic signed [IW-1:0] point_x;
		logic signed [IW-1:0] point_y;
		logic signed [IW-1:0] point_z;
	} in_t;

	typedef struct packed {
		logic signed [UW-1:0] normal_x;
		logic signed [UW-1:0] normal_y;
		logic signed [UW-1:0] normal_z;
		logic signed [UW-1:0] fiber_x;
		logic signed [UW-1:0] fiber_y;
		logic signed [UW-1:0] fiber_z;
		logic signed [UW-1:0] second_fiber_x;
		logic signed [UW-1:0] second_fiber_y;
		logic signed [UW-1:0] second_fiber_z;
		logic signed [UW-1:0] sheet_x;
		logic signed [UW-1:0] sheet_y;
		logic signed [UW-1:0] sheet_z;
	} out_t;

endpackage

// ===== rtl/ffg_in_if.sv =====
// ----------------------------------------------------------------------------
// ffg_in_if
// Request channel carrying a gradient and a point.
// ----------------------------------------------------------------------------
interface ffg_in_if;
	import ffg_pkg::*;

	logic valid;
	logic ready;
	in_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/ffg_out_if.sv =====
// ----------------------------------------------------------------------------
// ffg_out_if
// Result channel carrying the normal, both fibers and the sheet direction.
// ----------------------------------------------------------------------------
interface ffg_out_if;
	import ffg_pkg::*;

	logic valid;
	logic ready;
	out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fiber_frame_from_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// fiber_frame_from_gradient_unit
// Pipeline: five normalizers of 54 stages in series (the two fiber ones side by
// side), five frame stages, one output register.
// Throughput: one request per cycle while the skid entry is empty; a held result
// plus one skid entry absorb a stalled output before the pipeline freezes.
// Reset: clears all valid bits; cosine resets to 32767, sine to 0.
// ----------------------------------------------------------------------------
module fiber_frame_from_gradient_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	ffg_in_if.sink                       in_ch,
	ffg_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [ffg_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ffg_pkg::CW-1:0]       cfg_data
);
	import ffg_pkg::*;

	localparam wide_t ONE2 = VW'(64'd1 << (2 * FRAC));

	function automatic wide_t sext_in(logic [IW-1:0] x);
		return {{(VW - IW){x[IW-1]}}, x};
	endfunction

	function automatic wide_t dot2(q_t a, q_t b, q_t c, q_t d, logic sub);
		logic signed [2*UW-1:0] p0;
		logic signed [2*UW-1:0] p1;
		logic signed [2*UW:0]   s;
		p0 = a * b;
		p1 = c * d;
		s  = sub ? (p0 - p1) : (p0 + p1);
		return VW'(s);
	endfunction

	function automatic wvec_t cross3(qvec_t a, qvec_t b);
		wvec_t r;
		r[0] = dot2(a[1], b[2], a[2], b[1], 1'b1);
		r[1] = dot2(a[2], b[0], a[0], b[2], 1'b1);
		r[2] = dot2(a[0], b[1], a[1], b[0], 1'b1);
		return r;
	endfunction

	logic en;
	logic skid_valid_q;
	logic out_valid_q;
	out_t out_q;
	out_t skid_q;
	q_t   cos_q;
	q_t   sin_q;

	assign en          = !skid_valid_q;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd32767;
			sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COS: cos_q <= cfg_data;
				CFG_SIN: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: pick the source of the normal
	logic  v_s1;
	wvec_t vec_s1;
	side_t side_s1;
	logic  gnz;

	assign gnz = (in_ch.payload.grad_x != '0) || (in_ch.payload.grad_y != '0) ||
		(in_ch.payload.grad_z != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (gnz) begin
				vec_s1[0] <= -sext_in(in_ch.payload.grad_x);
				vec_s1[1] <= -sext_in(in_ch.payload.grad_y);
				vec_s1[2] <= -sext_in(in_ch.payload.grad_z);
			end else begin
				vec_s1[0] <= sext_in(in_ch.payload.point_x);
				vec_s1[1] <= sext_in(in_ch.payload.point_y);
				vec_s1[2] <= sext_in(in_ch.payload.point_z);
			end
			side_s1 <= '{point: {in_ch.payload.point_z, in_ch.payload.point_y,
				in_ch.payload.point_x}, nrm: '0, w: '0, f: '0, gf: '0};
		end
	end

	logic  v_n;
	qvec_t nrm_u;
	side_t side_n;

	ffg_unit3 u_nrm (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_vec(vec_s1), .in_side(side_s1),
		.out_valid(v_n), .out_vec(nrm_u), .out_side(side_n)
	);

	// stage 2: project z onto the plane (point x, y if the normal is on z)
	logic  v_s2;
	wvec_t vec_s2;
	side_t side_s2;
	logic  par;

	assign par = (nrm_u[0] == '0) && (nrm_u[1] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (par) begin
				vec_s2[0] <= sext_in(side_n.point[0]);
				vec_s2[1] <= sext_in(side_n.point[1]);
				vec_s2[2] <= '0;
			end else begin
				vec_s2[0] <= dot2('0, '0, nrm_u[2], nrm_u[0], 1'b1);
				vec_s2[1] <= dot2('0, '0, nrm_u[2], nrm_u[1], 1'b1);
				vec_s2[2] <= ONE2 + dot2('0, '0, nrm_u[2], nrm_u[2], 1'b1);
			end
			side_s2 <= '{point: side_n.point, nrm: nrm_u, w: side_n.w, f: side_n.f,
				gf: side_n.gf};
		end
	end

	logic  v_w;
	qvec_t w_u;
	side_t side_w;

	ffg_unit3 u_w (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .in_vec(vec_s2), .in_side(side_s2),
		.out_valid(v_w), .out_vec(w_u), .out_side(side_w)
	);

	// stage 3: w x normal
	logic  v_s3;
	wvec_t vec_s3;
	side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s3  <= cross3(w_u, side_w.nrm);
			side_s3 <= '{point: side_w.point, nrm: side_w.nrm, w: w_u, f: side_w.f,
				gf: side_w.gf};
		end
	end

	logic  v_v;
	qvec_t v_u;
	side_t side_v;

	ffg_unit3 u_v (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .in_vec(vec_s3), .in_side(side_s3),
		.out_valid(v_v), .out_vec(v_u), .out_side(side_v)
	);

	// stage 4: rotate within the plane
	logic  v_s4;
	wvec_t plus_s4;
	wvec_t minus_s4;
	side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plus_s4[i]  <= dot2(cos_q, v_u[i], sin_q, side_v.w[i], 1'b0);
				minus_s4[i] <= dot2(cos_q, v_u[i], sin_q, side_v.w[i], 1'b1);
			end
			side_s4 <= side_v;
		end
	end

	logic  v_f;
	logic  v_g;
	qvec_t f_u;
	qvec_t gf_u;
	side_t side_f;
	side_t side_g;

	ffg_unit3 u_f (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_vec(plus_s4), .in_side(side_s4),
		.out_valid(v_f), .out_vec(f_u), .out_side(side_f)
	);

	ffg_unit3 u_g (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_vec(minus_s4), .in_side(side_s4),
		.out_valid(v_g), .out_vec(gf_u), .out_side(side_g)
	);

	// stage 5: fiber x normal
	logic  v_s5;
	wvec_t vec_s5;
	side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_f & v_g;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s5        <= cross3(f_u, side_g.nrm);
			side_s5.point <= side_f.point;
			side_s5.nrm   <= side_g.nrm;
			side_s5.w     <= side_f.w;
			side_s5.f     <= f_u;
			side_s5.gf    <= gf_u;
		end
	end

	logic  v_o;
	qvec_t sh_u;
	side_t side_o;
	out_t  pres;

	ffg_unit3 u_sh (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .in_vec(vec_s5), .in_side(side_s5),
		.out_valid(v_o), .out_vec(sh_u), .out_side(side_o)
	);

	always_comb begin
		pres.normal_x       = side_o.nrm[0];
		pres.normal_y       = side_o.nrm[1];
		pres.normal_z       = side_o.nrm[2];
		pres.fiber_x        = side_o.f[0];
		pres.fiber_y        = side_o.f[1];
		pres.fiber_z        = side_o.f[2];
		pres.second_fiber_x = side_o.gf[0];
		pres.second_fiber_y = side_o.gf[1];
		pres.second_fiber_z = side_o.gf[2];
		pres.sheet_x        = sh_u[0];
		pres.sheet_y        = sh_u[1];
		pres.sheet_z        = sh_u[2];
	end

	// output register with one skid entry
	logic take;

	assign take = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= v_o;
			end
		end else if (v_o && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_valid_q ? skid_q : pres;
		end else if (en) begin
			skid_q <= pres;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;

endmodule

// ===== rtl/ffg_unit3.sv =====
// ----------------------------------------------------------------------------
// ffg_unit3
// Pipelined vector normalizer: magnitude alignment, sum of squares, one root
// bit per stage, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module ffg_unit3 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  ffg_pkg::wvec_t in_vec,
	input  ffg_pkg::side_t in_side,
	output logic           out_valid,
	output ffg_pkg::qvec_t out_vec,
	output ffg_pkg::side_t out_side
);
	import ffg_pkg::*;

	localparam logic [PW-1:0] TOP_POS = PW'(NW - 1);
	localparam logic [QB-1:0] QMAX = QB'((64'd1 << FRAC) - 64'd1);

	logic               v_s1;
	logic [2:0][MW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic [MW-1:0]      or_s1;
	side_t              side_s1;
	logic [2:0][MW-1:0] mag_c;
	logic [2:0]         neg_c;
	logic [VW-1:0]      abs_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = in_vec[i][VW-1];
			abs_c[i] = neg_c[i] ? (~in_vec[i] + VW'(1)) : in_vec[i];
			mag_c[i] = abs_c[i][MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			neg_s1  <= neg_c;
			or_s1   <= mag_c[0] | mag_c[1] | mag_c[2];
			side_s1 <= in_side;
		end
	end

	// leading one of the merged magnitudes
	logic               v_s2;
	logic [PW-1:0]      pos_s2;
	logic               z_s2;
	logic [2:0][MW-1:0] mag_s2;
	logic [2:0]         neg_s2;
	side_t              side_s2;
	logic [PW-1:0]      pos_c;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (or_s1[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2  <= pos_c;
			z_s2    <= (or_s1 == '0);
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
		end
	end

	// align
	logic               v_s3;
	logic [2:0][NW-1:0] m_s3;
	logic               z_s3;
	logic [2:0]         neg_s3;
	side_t              side_s3;
	logic [MW-1:0]      sh_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 > TOP_POS) begin
				sh_c[i] = mag_s2[i] >> (pos_s2 - TOP_POS);
			end else begin
				sh_c[i] = mag_s2[i] << (TOP_POS - pos_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= sh_c[i][NW-1:0];
			end
			z_s3    <= z_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
		end
	end

	// squares
	logic                 v_s4;
	logic [2:0][2*NW-1:0] sq_s4;
	logic [2:0][NW-1:0]   m_s4;
	logic                 z_s4;
	logic [2:0]           neg_s4;
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= m_s3[i] * m_s3[i];
			end
			m_s4    <= m_s3;
			z_s4    <= z_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
		end
	end

	// sum of squares, then one root bit per stage
	logic [SW-1:0]      sq_n    [0:SQ_STEPS];
	logic [SW-1:0]      sq_r    [0:SQ_STEPS];
	logic               sq_v    [0:SQ_STEPS];
	logic [2:0][NW-1:0] sq_m    [0:SQ_STEPS];
	logic [2:0]         sq_neg  [0:SQ_STEPS];
	logic               sq_z    [0:SQ_STEPS];
	side_t              sq_side [0:SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_n[0]    <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			sq_r[0]    <= '0;
			sq_m[0]    <= m_s4;
			sq_neg[0]  <= neg_s4;
			sq_z[0]    <= z_s4;
			sq_side[0] <= side_s4;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
		logic [SW-1:0] trial;
		logic          ge;

		assign trial = sq_r[k] + BIT;
		assign ge    = (sq_n[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_n[k+1]    <= ge ? (sq_n[k] - trial) : sq_n[k];
				sq_r[k+1]    <= ge ? ((sq_r[k] >> 1) + BIT) : (sq_r[k] >> 1);
				sq_m[k+1]    <= sq_m[k];
				sq_neg[k+1]  <= sq_neg[k];
				sq_z[k+1]    <= sq_z[k];
				sq_side[k+1] <= sq_side[k];
			end
		end
	end

	// rounded division, one quotient bit per stage
	logic [2:0][RW-1:0] dv_rem  [0:QB];
	logic [2:0][QB-1:0] dv_low  [0:QB];
	logic [2:0][QB-1:0] dv_q    [0:QB];
	logic [RW-1:0]      dv_r    [0:QB];
	logic               dv_v    [0:QB];
	logic [2:0]         dv_neg  [0:QB];
	logic               dv_z    [0:QB];
	side_t              dv_side [0:QB];
	logic [RW-1:0]      root_c;
	logic [DNW-1:0]     num_c   [3];

	assign root_c = sq_r[SQ_STEPS][RW-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = DNW'({sq_m[SQ_STEPS][i], {FRAC{1'b0}}}) + DNW'(root_c >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= RW'(num_c[i][DNW-1:QB]);
				dv_low[0][i] <= num_c[i][QB-1:0];
				dv_q[0][i]   <= '0;
			end
			dv_r[0]    <= root_c;
			dv_neg[0]  <= sq_neg[SQ_STEPS];
			dv_z[0]    <= sq_z[SQ_STEPS];
			dv_side[0] <= sq_side[SQ_STEPS];
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [RW:0] cat  [3];
		logic [RW:0] diff [3];
		logic [2:0]  ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				cat[i]  = {dv_rem[j][i], dv_low[j][i][QB-1-j]};
				ge[i]   = (cat[i] >= {1'b0, dv_r[j]});
				diff[i] = ge[i] ? (cat[i] - {1'b0, dv_r[j]}) : cat[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem[j+1][i] <= diff[i][RW-1:0];
					dv_q[j+1][i]   <= {dv_q[j][i][QB-2:0], ge[i]};
				end
				dv_low[j+1]  <= dv_low[j];
				dv_r[j+1]    <= dv_r[j];
				dv_neg[j+1]  <= dv_neg[j];
				dv_z[j+1]    <= dv_z[j];
				dv_side[j+1] <= dv_side[j];
			end
		end
	end

	// sign and saturate
	qvec_t res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_z[QB]) begin
				res_c[i] = '0;
			end else if (dv_neg[QB][i]) begin
				res_c[i] = UW'(~dv_q[QB][i] + QB'(1));
			end else if (dv_q[QB][i] > QMAX) begin
				res_c[i] = UW'(QMAX);
			end else begin
				res_c[i] = UW'(dv_q[QB][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec  <= res_c;
			out_side <= dv_side[QB];
		end
	end

endmodule

// ===== rtl/ffg_checker.sv =====
// ----------------------------------------------------------------------------
// ffg_checker
// Port-level checks of the fiber frame block's flow control.
// ----------------------------------------------------------------------------
module ffg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input ffg_pkg::out_t out_payload
);
	import ffg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result changed while stalled");

	a_busy_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("request refused with no result pending");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("skid entry not drained");

	a_fall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("request port closed without output stall");

endmodule

bind fiber_frame_from_gradient_unit ffg_checker u_ffg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_payload(out_ch.payload)
);
